/* hdl/dmm_pkg.sv */
// Package for the double-ended queue with min/max report.
// Holds shared widths, operation and status codes, and the command/status structs.
// No dependencies.
package dmm_pkg;

  localparam int VALUE_W       = 17;
  localparam int FUNC_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [VALUE_W-1:0] EMPTY_MIN = 17'd100000;
  localparam logic [VALUE_W-1:0] EMPTY_MAX = 17'd0;

  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic load;     // capture the input beat
    logic exec;     // apply the push or pop
    logic scan;     // step the min/max scan
    logic publish;  // move the result into the output register
  } dmm_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dmm_stat_t;

endpackage

/* hdl/deque_with_min_max_unit.sv */
// Top level of the double-ended queue with min/max report.
// Joins dmm_ctrl and dmm_datapath; depends on dmm_pkg.
//
// Holds up to DEPTH values in a ring; each input beat pushes its value at the
// front or back or pops the front or back entry, and yields one output beat
// with the largest and smallest stored values (0 and 100000 when empty), the
// entry count and a status code (ok, pop on empty ignored, push on full
// dropped). One item at a time: after accept the item is captured, the
// update is applied, the scan reads the entries left after the update,
// one stored value per cycle through the single memory read port, and the
// result is published once the output register is free.
// The output register lets the next beat be accepted while a result waits.
module deque_with_min_max_unit #(
  parameter int DEPTH = dmm_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int OUT_W = ((2 * dmm_pkg::VALUE_W + CW + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [23:0]                  s_tdata,   // value[16:0], zero pad
  input  logic [dmm_pkg::FUNC_W-1:0]   s_tuser,   // func[1:0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [OUT_W-1:0]             m_tdata,   // largest, smallest, entries, zero pad
  output logic [dmm_pkg::STATUS_W-1:0] m_tuser    // status[1:0]
);

  dmm_pkg::dmm_cmd_t           cmd;
  dmm_pkg::dmm_stat_t          stat;
  logic [dmm_pkg::VALUE_W-1:0] largest;
  logic [dmm_pkg::VALUE_W-1:0] smallest;
  logic [CW-1:0]               entries;

  dmm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dmm_datapath #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_func  (s_tuser),
    .in_value (s_tdata[dmm_pkg::VALUE_W-1:0]),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .largest  (largest),
    .smallest (smallest),
    .entries  (entries),
    .status   (m_tuser)
  );

  always_comb begin
    m_tdata = '0;
    m_tdata[dmm_pkg::VALUE_W-1:0]                    = largest;
    m_tdata[2*dmm_pkg::VALUE_W-1:dmm_pkg::VALUE_W]   = smallest;
    m_tdata[2*dmm_pkg::VALUE_W+CW-1:2*dmm_pkg::VALUE_W] = entries;
  end

endmodule

/* hdl/dmm_ctrl.sv */
// Controller state machine for the double-ended queue with min/max report.
// Sequences capture, update, scan and publish; depends on dmm_pkg.
module dmm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  dmm_pkg::dmm_stat_t stat,
  output dmm_pkg::dmm_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/dmm_datapath.sv */
// Datapath for the double-ended queue with min/max report.
// Ring storage, front pointer, fill count, min/max scan and output register;
// depends on dmm_pkg.
module dmm_datapath #(
  parameter int DEPTH = dmm_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dmm_pkg::FUNC_W-1:0]    in_func,
  input  logic [dmm_pkg::VALUE_W-1:0]   in_value,
  input  dmm_pkg::dmm_cmd_t             cmd,
  output dmm_pkg::dmm_stat_t            stat,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dmm_pkg::VALUE_W-1:0]   largest,
  output logic [dmm_pkg::VALUE_W-1:0]   smallest,
  output logic [CW-1:0]                 entries,
  output logic [dmm_pkg::STATUS_W-1:0]  status
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

  logic [dmm_pkg::VALUE_W-1:0] mem [DEPTH];

  logic [dmm_pkg::FUNC_W-1:0]   op_func;
  logic [dmm_pkg::VALUE_W-1:0]  op_value;
  logic [AW-1:0]                front;
  logic [AW-1:0]                front_next;
  logic [CW-1:0]                fill;
  logic [CW-1:0]                fill_next;
  logic [dmm_pkg::STATUS_W-1:0] op_status;
  logic [dmm_pkg::STATUS_W-1:0] op_status_next;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;

  logic [AW-1:0]                scan_ptr;
  logic [CW-1:0]                issued;
  logic                         rd_valid;
  logic [dmm_pkg::VALUE_W-1:0]  rd_data;
  logic [dmm_pkg::VALUE_W-1:0]  cur_max;
  logic [dmm_pkg::VALUE_W-1:0]  cur_min;

  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [SW-1:0] back_sum;
  logic [AW-1:0] back_pos;
  logic          is_full;
  logic          is_empty;
  logic          issue;

  assign front_dec = (front == '0) ? LAST_POS : front - AW'(1);
  assign front_inc = (front == LAST_POS) ? '0 : front + AW'(1);
  assign back_sum  = SW'(front) + SW'(fill);
  assign back_pos  = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
  assign is_full   = (fill == FULL_CNT);
  assign is_empty  = (fill == '0);

  always_comb begin
    front_next     = front;
    fill_next      = fill;
    op_status_next = dmm_pkg::STATUS_OK;
    wr_en          = 1'b0;
    wr_addr        = back_pos;
    case (op_func)
      dmm_pkg::FUNC_PUSH_FRONT: begin
        if (is_full) begin
          op_status_next = dmm_pkg::STATUS_PUSH_FULL;
        end else begin
          front_next = front_dec;
          fill_next  = fill + CW'(1);
          wr_en      = 1'b1;
          wr_addr    = front_dec;
        end
      end
      dmm_pkg::FUNC_PUSH_BACK: begin
        if (is_full) begin
          op_status_next = dmm_pkg::STATUS_PUSH_FULL;
        end else begin
          fill_next = fill + CW'(1);
          wr_en     = 1'b1;
        end
      end
      dmm_pkg::FUNC_POP_FRONT: begin
        if (is_empty) begin
          op_status_next = dmm_pkg::STATUS_POP_EMPTY;
        end else begin
          front_next = front_inc;
          fill_next  = fill - CW'(1);
        end
      end
      dmm_pkg::FUNC_POP_BACK: begin
        if (is_empty) begin
          op_status_next = dmm_pkg::STATUS_POP_EMPTY;
        end else begin
          fill_next = fill - CW'(1);
        end
      end
      default: begin
        op_status_next = dmm_pkg::STATUS_OK;
      end
    endcase
  end

  assign issue          = cmd.scan && (issued != fill);
  assign stat.scan_done = (issued == fill) && !rd_valid;
  assign stat.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= op_value;
    end
    if (issue) begin
      rd_data <= mem[scan_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func  <= in_func;
      op_value <= in_value;
    end
    if (cmd.exec) begin
      op_status <= op_status_next;
      scan_ptr  <= front_next;
      cur_max   <= dmm_pkg::EMPTY_MAX;
      cur_min   <= dmm_pkg::EMPTY_MIN;
    end else if (cmd.scan) begin
      if (issue) begin
        scan_ptr <= (scan_ptr == LAST_POS) ? '0 : scan_ptr + AW'(1);
      end
      if (rd_valid) begin
        if (rd_data > cur_max) begin
          cur_max <= rd_data;
        end
        if (rd_data < cur_min) begin
          cur_min <= rd_data;
        end
      end
    end
    if (cmd.publish) begin
      largest  <= cur_max;
      smallest <= cur_min;
      entries  <= fill;
      status   <= op_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      fill     <= '0;
      issued   <= '0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        front    <= front_next;
        fill     <= fill_next;
        issued   <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.scan) begin
        rd_valid <= issue;
        if (issue) begin
          issued <= issued + CW'(1);
        end
      end
      if (cmd.publish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
